FILE: rtl/nhbci_pkg.sv
// ----------------------------------------------------------------------------
// Name hash bucket chain insert package
// Shared payload types, field widths and constants for the bucket chain
// insert block and its remainder unit.
// ----------------------------------------------------------------------------
package nhbci_pkg;

   localparam int HASH_W               = 32;
   localparam int CHAR_W               = 16;
   localparam int OFFSET_W             = 32;
   localparam int COUNT_W              = 11;
   localparam int INDEX_W              = 10;
   localparam int CSR_INDEX_W          = 8;
   localparam int BUCKET_DEPTH_DEFAULT = 1024;

   localparam logic [HASH_W-1:0]   HASH_SEED  = 32'd123456789;
   localparam int                  ROT_RIGHT  = 5;
   localparam int                  ROT_LEFT   = 27;
   localparam logic [OFFSET_W-1:0] EMPTY_HEAD = '1;
   localparam logic [COUNT_W-1:0]  COUNT_MIN  = 11'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_DIR_BUCKET_COUNT  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILE_BUCKET_COUNT = 8'd1;

   typedef struct packed {
      logic                table_select;
      logic [OFFSET_W-1:0] parent_offset;
      logic [CHAR_W-1:0]   name_char;
      logic                char_valid;
      logic                name_end;
      logic [OFFSET_W-1:0] entry_offset;
   } req_type;

   typedef struct packed {
      logic [HASH_W-1:0]   raw_hash;
      logic [INDEX_W-1:0]  bucket_index;
      logic [OFFSET_W-1:0] previous_head;
   } rsp_type;

   typedef struct packed {
      logic               done;
      logic [COUNT_W-1:0] remainder;
   } div_result_type;

endpackage

FILE: rtl/nhbci_rem_unit.sv
// ----------------------------------------------------------------------------
// Name hash remainder unit
// Restoring division, one dividend bit per cycle, that leaves the remainder
// of a 32-bit hash by an 11-bit bucket count.
// ----------------------------------------------------------------------------
module nhbci_rem_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [nhbci_pkg::HASH_W-1:0]    dividend,
   input  logic [nhbci_pkg::COUNT_W-1:0]   divisor,
   output nhbci_pkg::div_result_type       result
);

   localparam int STEP_W = $clog2(nhbci_pkg::HASH_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(nhbci_pkg::HASH_W - 1);

   logic                            run_ff, run_in;
   logic [STEP_W-1:0]               step_ff, step_in;
   logic [nhbci_pkg::HASH_W-1:0]    shift_ff, shift_in;
   logic [nhbci_pkg::COUNT_W-1:0]   rem_ff, rem_in;
   logic [nhbci_pkg::COUNT_W-1:0]   divisor_ff, divisor_in;
   logic [nhbci_pkg::COUNT_W:0]     trial;

   always_comb begin
      run_in     = run_ff;
      step_in    = step_ff;
      shift_in   = shift_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      trial      = {rem_ff, shift_ff[nhbci_pkg::HASH_W-1]};
      if (start) begin
         run_in     = 1'b1;
         step_in    = '0;
         shift_in   = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (run_ff) begin
         shift_in = {shift_ff[nhbci_pkg::HASH_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = nhbci_pkg::COUNT_W'(trial - {1'b0, divisor_ff});
         end else begin
            rem_in = nhbci_pkg::COUNT_W'(trial);
         end
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         step_ff <= step_in;
      end
      shift_ff   <= shift_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign result.done      = run_ff && (step_ff == LAST_STEP);
   assign result.remainder = rem_ff;

endmodule

FILE: rtl/name_hash_bucket_chain_insert_top.sv
// ----------------------------------------------------------------------------
// Name hash bucket chain insert
// Hashes a name one character per transfer and links a new entry at the head
// of a bucket in the directory or the file hash table.
// ----------------------------------------------------------------------------
// After reset the block holds busy high while it sets every bucket head of both
// tables to empty. A character transfer leaves busy low. A transfer that ends a
// name holds busy high while the bit-serial remainder unit runs, then while it
// reads the bucket head memory and then while it writes the new head. The
// result is shown for one cycle in the cycle after the head write, and the
// receiver cannot stall it.
module name_hash_bucket_chain_insert_top #(
   parameter int BUCKET_DEPTH = nhbci_pkg::BUCKET_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  nhbci_pkg::req_type                  req_item,
   output logic                                rsp_valid,
   output nhbci_pkg::rsp_type                  rsp_item,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [nhbci_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [nhbci_pkg::COUNT_W-1:0]       csr_data
);

   localparam int AW = $clog2(BUCKET_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(BUCKET_DEPTH - 1);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_WRITE = 3'd4;

   logic [2:0]                         state_ff, state_in;
   logic [AW-1:0]                      clear_addr_ff, clear_addr_in;
   logic [nhbci_pkg::COUNT_W-1:0]      dir_count_ff, dir_count_in;
   logic [nhbci_pkg::COUNT_W-1:0]      file_count_ff, file_count_in;
   logic [nhbci_pkg::HASH_W-1:0]       hash_ff, hash_in;
   logic                               in_name_ff, in_name_in;
   logic                               sel_ff, sel_in;
   logic [nhbci_pkg::OFFSET_W-1:0]     entry_ff, entry_in;
   logic [nhbci_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic [AW-1:0]                      idx_ff, idx_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   nhbci_pkg::rsp_type                 rsp_ff, rsp_in;

   logic [nhbci_pkg::OFFSET_W-1:0]     dir_mem [BUCKET_DEPTH];
   logic [nhbci_pkg::OFFSET_W-1:0]     file_mem [BUCKET_DEPTH];
   logic [nhbci_pkg::OFFSET_W-1:0]     dir_rd_ff;
   logic [nhbci_pkg::OFFSET_W-1:0]     file_rd_ff;
   logic [nhbci_pkg::OFFSET_W-1:0]     prev_head;

   logic                               accept;
   logic [nhbci_pkg::HASH_W-1:0]       hash_base;
   logic [nhbci_pkg::HASH_W-1:0]       hash_next;
   logic [nhbci_pkg::COUNT_W-1:0]      raw_count;
   logic [nhbci_pkg::COUNT_W-1:0]      eff_count;
   logic                               div_start;
   nhbci_pkg::div_result_type          div_res;

   logic                               dir_we;
   logic                               file_we;
   logic [AW-1:0]                      wr_addr;
   logic [nhbci_pkg::OFFSET_W-1:0]     wr_data;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      hash_base = in_name_ff ? hash_ff : (req_item.parent_offset ^ nhbci_pkg::HASH_SEED);
      hash_next = hash_base;
      if (req_item.char_valid) begin
         hash_next = ((hash_base >> nhbci_pkg::ROT_RIGHT) | (hash_base << nhbci_pkg::ROT_LEFT))
                     ^ {{(nhbci_pkg::HASH_W - nhbci_pkg::CHAR_W){1'b0}}, req_item.name_char};
      end
   end

   always_comb begin
      raw_count = req_item.table_select ? file_count_ff : dir_count_ff;
      if (raw_count < nhbci_pkg::COUNT_MIN) begin
         eff_count = nhbci_pkg::COUNT_MIN;
      end else if (32'(raw_count) > 32'(BUCKET_DEPTH)) begin
         eff_count = nhbci_pkg::COUNT_W'(BUCKET_DEPTH);
      end else begin
         eff_count = raw_count;
      end
   end

   assign div_start = accept && req_item.name_end;

   nhbci_rem_unit u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (hash_next),
      .divisor  (eff_count),
      .result   (div_res)
   );

   assign prev_head = sel_ff ? file_rd_ff : dir_rd_ff;

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      dir_count_in  = dir_count_ff;
      file_count_in = file_count_ff;
      hash_in       = hash_ff;
      in_name_in    = in_name_ff;
      sel_in        = sel_ff;
      entry_in      = entry_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      dir_we        = 1'b0;
      file_we       = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = entry_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            nhbci_pkg::CSR_DIR_BUCKET_COUNT:  dir_count_in  = csr_data;
            nhbci_pkg::CSR_FILE_BUCKET_COUNT: file_count_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            dir_we        = 1'b1;
            file_we       = 1'b1;
            wr_addr       = clear_addr_ff;
            wr_data       = nhbci_pkg::EMPTY_HEAD;
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               hash_in    = hash_next;
               in_name_in = !req_item.name_end;
               if (req_item.name_end) begin
                  sel_in   = req_item.table_select;
                  entry_in = req_item.entry_offset;
                  count_in = eff_count;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            idx_in   = AW'(div_res.remainder);
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            dir_we                = !sel_ff;
            file_we               = sel_ff;
            rsp_valid_in          = 1'b1;
            rsp_in.raw_hash       = hash_ff;
            rsp_in.bucket_index   = nhbci_pkg::INDEX_W'(idx_ff);
            rsp_in.previous_head  = prev_head;
            state_in              = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         dir_count_ff  <= nhbci_pkg::COUNT_MIN;
         file_count_ff <= nhbci_pkg::COUNT_MIN;
         hash_ff       <= '0;
         in_name_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         dir_count_ff  <= dir_count_in;
         file_count_ff <= file_count_in;
         hash_ff       <= hash_in;
         in_name_ff    <= in_name_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      sel_ff   <= sel_in;
      entry_ff <= entry_in;
      count_ff <= count_in;
      idx_ff   <= idx_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (dir_we) begin
         dir_mem[wr_addr] <= wr_data;
      end
      if (state_ff == ST_READ) begin
         dir_rd_ff <= dir_mem[AW'(div_res.remainder)];
      end
   end

   always_ff @(posedge clock) begin
      if (file_we) begin
         file_mem[wr_addr] <= wr_data;
      end
      if (state_ff == ST_READ) begin
         file_rd_ff <= file_mem[AW'(div_res.remainder)];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // A result follows only the cycle that writes the new bucket head.
   a_rsp_after_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_WRITE))
      else $error("result transfer without a head write");

   // The remainder unit finishes only while the controller waits for it.
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> (state_ff == ST_DIV))
      else $error("remainder unit finished outside the divide phase");

   // The bucket written always lies below the bucket count in use.
   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> (32'(idx_ff) < 32'(count_ff)))
      else $error("bucket index not below the bucket count");

   // The clear pass ends before the first item can be taken.
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> busy)
      else $error("block idle during the clear pass");

endmodule

FILE: sim/tb_name_hash_bucket_chain_insert_top.sv
// ----------------------------------------------------------------------------
// Name hash bucket chain insert testbench
// Sends directed and random names, one character per transfer, to the block.
// A scoreboard keeps its own hash state and bucket head tables. It predicts
// the hash, bucket index and previous head for every name end, and checks
// each result strobe against the oldest prediction. The bucket counts are
// rewritten between phases, including out-of-range values and one change in
// the middle of a name. The sender's idle rate changes every two phases.
// ----------------------------------------------------------------------------
module tb_name_hash_bucket_chain_insert_top;

   localparam int BUCKET_DEPTH     = nhbci_pkg::BUCKET_DEPTH_DEFAULT;
   localparam int SLOT_W           = $clog2(BUCKET_DEPTH);
   localparam int NAME_END_LATENCY = 40;
   localparam int STALL_LIMIT      = 5000;
   localparam int RANDOM_ITEMS     = 1830;
   localparam int PHASES           = 6;

   class bucket_chain_scoreboard;
      logic [nhbci_pkg::HASH_W-1:0]   running_hash;
      bit                             in_name;
      logic [nhbci_pkg::COUNT_W-1:0]  dir_count;
      logic [nhbci_pkg::COUNT_W-1:0]  file_count;
      logic [nhbci_pkg::OFFSET_W-1:0] dir_heads [BUCKET_DEPTH];
      logic [nhbci_pkg::OFFSET_W-1:0] file_heads [BUCKET_DEPTH];
      nhbci_pkg::rsp_type             pending_links [$];
      int                             failures;

      function new();
         running_hash = '0;
         in_name      = 1'b0;
         dir_count    = nhbci_pkg::COUNT_MIN;
         file_count   = nhbci_pkg::COUNT_MIN;
         failures     = 0;
         foreach (dir_heads[i]) begin
            dir_heads[i]  = nhbci_pkg::EMPTY_HEAD;
            file_heads[i] = nhbci_pkg::EMPTY_HEAD;
         end
      endfunction

      function void set_bucket_count(logic [nhbci_pkg::CSR_INDEX_W-1:0] index,
                                     logic [nhbci_pkg::COUNT_W-1:0] value);
         if (index == nhbci_pkg::CSR_DIR_BUCKET_COUNT) begin
            dir_count = value;
         end else if (index == nhbci_pkg::CSR_FILE_BUCKET_COUNT) begin
            file_count = value;
         end
      endfunction

      function void fold_request(nhbci_pkg::req_type item);
         logic [nhbci_pkg::HASH_W-1:0] h;
         logic [nhbci_pkg::HASH_W-1:0] divisor;
         logic [nhbci_pkg::HASH_W-1:0] slot;
         nhbci_pkg::rsp_type           link;
         h = in_name ? running_hash : (item.parent_offset ^ nhbci_pkg::HASH_SEED);
         if (item.char_valid) begin
            h = ((h >> nhbci_pkg::ROT_RIGHT) | (h << nhbci_pkg::ROT_LEFT))
                ^ nhbci_pkg::HASH_W'(item.name_char);
         end
         running_hash = h;
         in_name      = !item.name_end;
         if (item.name_end) begin
            divisor = item.table_select ? nhbci_pkg::HASH_W'(file_count)
                                        : nhbci_pkg::HASH_W'(dir_count);
            if (divisor < nhbci_pkg::HASH_W'(nhbci_pkg::COUNT_MIN)) begin
               divisor = nhbci_pkg::HASH_W'(nhbci_pkg::COUNT_MIN);
            end
            if (divisor > nhbci_pkg::HASH_W'(BUCKET_DEPTH)) begin
               divisor = nhbci_pkg::HASH_W'(BUCKET_DEPTH);
            end
            slot              = h % divisor;
            link.raw_hash     = h;
            link.bucket_index = slot[nhbci_pkg::INDEX_W-1:0];
            if (item.table_select) begin
               link.previous_head           = file_heads[slot[SLOT_W-1:0]];
               file_heads[slot[SLOT_W-1:0]] = item.entry_offset;
            end else begin
               link.previous_head          = dir_heads[slot[SLOT_W-1:0]];
               dir_heads[slot[SLOT_W-1:0]] = item.entry_offset;
            end
            pending_links = {pending_links, link};
         end
      endfunction

      function void check_link(nhbci_pkg::rsp_type got);
         nhbci_pkg::rsp_type want;
         if (pending_links.size() == 0) begin
            failures++;
            $display("%0t: unexpected result raw_hash %h bucket_index %0d previous_head %h",
                     $time, got.raw_hash, got.bucket_index, got.previous_head);
            return;
         end
         want = pending_links.pop_front();
         if (got.raw_hash !== want.raw_hash) begin
            failures++;
            $display("%0t: raw_hash expected %h actual %h",
                     $time, want.raw_hash, got.raw_hash);
         end
         if (got.bucket_index !== want.bucket_index) begin
            failures++;
            $display("%0t: bucket_index expected %0d actual %0d",
                     $time, want.bucket_index, got.bucket_index);
         end
         if (got.previous_head !== want.previous_head) begin
            failures++;
            $display("%0t: previous_head expected %h actual %h",
                     $time, want.previous_head, got.previous_head);
         end
      endfunction
   endclass

   logic                              clock     = 1'b0;
   logic                              reset     = 1'b1;
   logic                              start     = 1'b0;
   logic                              busy;
   nhbci_pkg::req_type                req_item  = '0;
   logic                              rsp_valid;
   nhbci_pkg::rsp_type                rsp_item;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [nhbci_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [nhbci_pkg::COUNT_W-1:0]     csr_data  = '0;

   bucket_chain_scoreboard links = new();
   int                     sent        = 0;
   int                     idle_pct    = 0;
   int                     quiet_cycles = 0;

   name_hash_bucket_chain_insert_top #(
      .BUCKET_DEPTH(BUCKET_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            links.check_link(rsp_item);
         end
         if (start && !busy) begin
            links.fold_request(req_item);
         end
         if (csr_valid && csr_ready) begin
            links.set_bucket_count(csr_index, csr_data);
         end
         if (rsp_valid || (start && !busy) || (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("[FAIL] regression broken");
               $finish;
            end
         end
      end
   end

   function automatic nhbci_pkg::req_type pack_item(logic sel,
                                                    logic [nhbci_pkg::OFFSET_W-1:0] parent,
                                                    logic [nhbci_pkg::CHAR_W-1:0] code,
                                                    logic fold, logic last,
                                                    logic [nhbci_pkg::OFFSET_W-1:0] entry);
      nhbci_pkg::req_type item;
      item.table_select  = sel;
      item.parent_offset = parent;
      item.name_char     = code;
      item.char_valid    = fold;
      item.name_end      = last;
      item.entry_offset  = entry;
      return item;
   endfunction

   function automatic nhbci_pkg::req_type random_item();
      nhbci_pkg::req_type item;
      item.table_select  = 1'($urandom_range(1));
      item.parent_offset = $urandom;
      item.name_char     = ($urandom_range(3) == 0)
                           ? nhbci_pkg::CHAR_W'($urandom_range(126, 32))
                           : nhbci_pkg::CHAR_W'($urandom_range(16'hFFFF));
      item.char_valid    = 1'b1;
      item.name_end      = 1'b0;
      case ($urandom_range(19))
         0: item.entry_offset = '1;
         1: item.entry_offset = '0;
         default: item.entry_offset = $urandom;
      endcase
      return item;
   endfunction

   task automatic drive_item(input nhbci_pkg::req_type item);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy !== 1'b0);
      sent++;
   endtask

   task automatic drain_links();
      @(negedge clock);
      start <= 1'b0;
      while (links.pending_links.size() != 0) @(posedge clock);
   endtask

   task automatic write_bucket_count(input logic [nhbci_pkg::CSR_INDEX_W-1:0] index,
                                     input logic [nhbci_pkg::COUNT_W-1:0] value);
      drain_links();
      repeat (NAME_END_LATENCY) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drive_name();
      nhbci_pkg::req_type item;
      int                 length;
      int                 pick;
      int                 i;
      pick = $urandom_range(99);
      if (pick < 8) begin
         length = 0;
      end else if (pick < 92) begin
         length = $urandom_range(8, 1);
      end else begin
         length = $urandom_range(40, 9);
      end
      for (i = 0; i < length; i++) begin
         if ($urandom_range(19) == 0) begin
            item = random_item();
            item.char_valid = 1'b0;
            drive_item(item);
         end
         item = random_item();
         item.name_end = (i == length - 1) && ($urandom_range(9) < 7);
         drive_item(item);
         if (item.name_end) begin
            return;
         end
      end
      item = random_item();
      item.char_valid = 1'b0;
      item.name_end   = 1'b1;
      drive_item(item);
   endtask

   initial begin
      logic [nhbci_pkg::COUNT_W-1:0] dir_plan [PHASES];
      logic [nhbci_pkg::COUNT_W-1:0] file_plan [PHASES];
      int                            directed_count;
      int                            phase;
      dir_plan  = '{11'd3, 11'd0, 11'd1024, 11'd2047, 11'd0, 11'd0};
      file_plan = '{11'd1024, 11'd2047, 11'd2, 11'd3, 11'd0, 11'd0};
      dir_plan[4]  = nhbci_pkg::COUNT_W'($urandom_range(1024, 3));
      file_plan[4] = nhbci_pkg::COUNT_W'($urandom_range(1024, 3));
      dir_plan[5]  = nhbci_pkg::COUNT_W'($urandom_range(2047));
      file_plan[5] = nhbci_pkg::COUNT_W'($urandom_range(2047));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty names first; the third one lands in the same bucket as the first.
      drive_item(pack_item(1'b0, 32'h0, 16'h0, 1'b0, 1'b1, 32'h0));
      drive_item(pack_item(1'b1, '1, 16'hFFFF, 1'b0, 1'b1, '1));
      drive_item(pack_item(1'b0, 32'h0, 16'h1234, 1'b0, 1'b1, 32'hA5A5_0001));
      drive_item(pack_item(1'b1, '1, 16'hFFFF, 1'b1, 1'b1, 32'h1234_5678));
      drive_item(pack_item(1'b0, 32'h8000_0001, 16'h0000, 1'b1, 1'b0, 32'hDEAD_BEEF));
      drive_item(pack_item(1'b1, 32'h0, 16'hFFFF, 1'b1, 1'b0, 32'h0));
      drive_item(pack_item(1'b0, '1, 16'h8000, 1'b1, 1'b1, 32'h0000_0002));
      drive_item(pack_item(1'b1, 32'h7FFF_FFFF, 16'h0041, 1'b1, 1'b0, '0));
      drive_item(pack_item(1'b0, 32'h0, 16'hFFFF, 1'b0, 1'b0, '0));
      drive_item(pack_item(1'b1, 32'h1, 16'h0042, 1'b1, 1'b0, '0));
      drive_item(pack_item(1'b1, 32'h2, 16'h0, 1'b0, 1'b1, 32'h8000_0000));
      drive_item(pack_item(1'b0, 32'h0, 16'h0, 1'b0, 1'b0, '0));
      drive_item(pack_item(1'b0, 32'h0, 16'h0, 1'b0, 1'b1, 32'h3));
      // The file bucket count changes while this name is still open.
      drive_item(pack_item(1'b1, 32'hFFFF_0000, 16'h0001, 1'b1, 1'b0, '0));
      write_bucket_count(nhbci_pkg::CSR_FILE_BUCKET_COUNT, 11'd1024);
      drive_item(pack_item(1'b1, 32'h0, 16'h0002, 1'b1, 1'b1, 32'h0000_FFFF));
      directed_count = sent;

      for (phase = 0; phase < PHASES; phase++) begin
         write_bucket_count(nhbci_pkg::CSR_DIR_BUCKET_COUNT, dir_plan[phase]);
         write_bucket_count(nhbci_pkg::CSR_FILE_BUCKET_COUNT, file_plan[phase]);
         idle_pct = (phase < 2) ? 22 : (phase < 4) ? 61 : 0;
         while (sent < directed_count + (phase + 1) * RANDOM_ITEMS / PHASES) begin
            drive_name();
            if ($urandom_range(39) == 0) begin
               drain_links();
            end
         end
      end

      drain_links();
      repeat (NAME_END_LATENCY) @(posedge clock);
      if (links.failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
